// ===== hw/rtl/rsn_pkg.sv =====
// Shared types, constants and helpers for the regular-spiking map neuron.
// Used by the channel interfaces, the controller, the datapath and the divider.
`default_nettype none

package rsn_pkg;

    localparam int FRAC_BITS   = 24;
    localparam int DW          = 32;
    localparam int MU_W        = 31;
    localparam int MUL_W       = DW + 1;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int ACC_W       = PROD_W - FRAC_BITS + 2;
    localparam int DIV_STEPS   = DW + FRAC_BITS;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic signed [DW-1:0] ONE = DW'(64'sd1 <<< FRAC_BITS);

    typedef enum logic [2:0] {
        MUL_SIG_SYN  = 3'd0,
        MUL_SIG_DC   = 3'd1,
        MUL_BETA_SYN = 3'd2,
        MUL_BETA_DC  = 3'd3,
        MUL_MU_X     = 3'd4,
        MUL_MU_BIAS  = 3'd5,
        MUL_MU_SIG   = 3'd6
    } t_mul_op;

    localparam t_mul_op MUL_LAST = MUL_MU_SIG;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALPHA      = 3'd0,
        CFG_MU         = 3'd1,
        CFG_SIGMA_BIAS = 3'd2,
        CFG_SIG_SYN    = 3'd3,
        CFG_BETA_SYN   = 3'd4,
        CFG_SIG_DC     = 3'd5,
        CFG_BETA_DC    = 3'd6
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_WAIT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic    load;
        logic    mul_en;
        t_mul_op mul_op;
        logic    finish;
    } t_dp_cmd;

    typedef struct packed {
        logic div_busy;
        logic out_hold;
    } t_dp_stat;

    // Saturate a wide accumulator value to the signed 32-bit range.
    function automatic logic signed [DW-1:0] sat_acc(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-DW:0] hi;
        hi = v[ACC_W-1:DW-1];
        if (hi == '0 || hi == '1) begin
            sat_acc = v[DW-1:0];
        end else if (v[ACC_W-1]) begin
            sat_acc = {1'b1, {(DW-1){1'b0}}};
        end else begin
            sat_acc = {1'b0, {(DW-1){1'b1}}};
        end
    endfunction

    // Reset constants are specified in Q8.24; rescale them to FRAC_BITS.
    function automatic logic signed [DW-1:0] rescale(input longint q24);
        longint v;
        if (FRAC_BITS >= 24) begin
            v = q24 <<< (FRAC_BITS - 24);
            if (v > longint'(32'sh7fffffff)) begin
                v = longint'(32'sh7fffffff);
            end else if (v < -longint'(64'sh80000000)) begin
                v = -longint'(64'sh80000000);
            end
        end else begin
            v = q24 >>> (24 - FRAC_BITS);
        end
        rescale = DW'(v);
    endfunction

    localparam logic signed [DW-1:0] RST_ALPHA      = rescale(64'sd61236838);
    localparam logic signed [DW-1:0] RST_MU         = rescale(64'sd8389);
    localparam logic signed [DW-1:0] RST_SIGMA_BIAS = rescale(64'sd1006633);
    localparam logic signed [DW-1:0] RST_SIG_GAIN   = rescale(64'sd16777216);
    localparam logic signed [DW-1:0] RST_BETA_GAIN  = rescale(64'sd2231370);
    localparam logic signed [DW-1:0] RST_X          = rescale(-64'sd15770583);
    localparam logic signed [DW-1:0] RST_Y          = rescale(-64'sd47335955);

endpackage

`default_nettype wire

// ===== hw/rtl/rsn_in_if.sv =====
// Input channel: valid/ready handshake carrying the two drive currents.
// Depends on rsn_pkg for the data width.
`default_nettype none

interface rsn_in_if
    import rsn_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic signed [DW-1:0] syn_current;
    logic signed [DW-1:0] dc_current;

    modport source (output valid, output syn_current, output dc_current, input ready);
    modport sink   (input valid, input syn_current, input dc_current, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rsn_out_if.sv =====
// Output channel: valid/ready handshake carrying new x, new y and the spike flag.
// Depends on rsn_pkg for the data width.
`default_nettype none

interface rsn_out_if
    import rsn_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic signed [DW-1:0] membrane;
    logic signed [DW-1:0] recovery;
    logic                 spike;

    modport source (output valid, output membrane, output recovery, output spike, input ready);
    modport sink   (input valid, input membrane, input recovery, input spike, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rsn_div.sv =====
// Bit-serial restoring divider for alpha * 2^FRAC_BITS / (1 - x), one quotient bit a cycle.
// Depends on rsn_pkg.
`default_nettype none

module rsn_div
    import rsn_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic signed [DW-1:0]   i_alpha,
    input  wire logic        [DW:0]     i_den,
    output logic                        o_busy,
    output logic signed [DW+1:0]        o_quot
);

    logic                   r_busy;
    logic [DIV_CNT_W-1:0]   r_cnt;
    logic [DIV_STEPS-1:0]   r_num;
    logic [DW:0]            r_rem;
    logic [DW:0]            r_quo;
    logic [DW:0]            r_den;
    logic                   r_neg;

    logic [DW-1:0]          alpha_mag;
    logic [DW+1:0]          trial;
    logic [DW+1:0]          diff;
    logic                   ge;
    logic signed [DW+1:0]   quo_ext;

    assign alpha_mag = i_alpha[DW-1] ? (~i_alpha + 1'b1) : i_alpha;
    assign trial     = {r_rem, r_num[DIV_STEPS-1]};
    assign diff      = trial - {1'b0, r_den};
    assign ge        = ~diff[DW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_CNT_W'(DIV_STEPS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Quotient magnitude never exceeds 2^31 on the branch that uses it,
    // so bits shifted out of the top of r_quo are zero.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= {alpha_mag, {FRAC_BITS{1'b0}}};
            r_rem <= '0;
            r_quo <= '0;
            r_den <= i_den;
            r_neg <= i_alpha[DW-1];
        end else if (r_busy) begin
            r_num <= {r_num[DIV_STEPS-2:0], 1'b0};
            r_rem <= ge ? diff[DW:0] : trial[DW:0];
            r_quo <= {r_quo[DW-1:0], ge};
        end
    end

    assign quo_ext = {1'b0, r_quo};
    assign o_quot  = r_neg ? -quo_ext : quo_ext;
    assign o_busy  = r_busy;

endmodule

`default_nettype wire

// ===== hw/rtl/rsn_dp.sv =====
// Datapath: config registers, neuron state, shared multiplier with accumulators,
// divider and the output register. Depends on rsn_pkg and rsn_div.
`default_nettype none

module rsn_dp
    import rsn_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic signed [DW-1:0]   i_syn,
    input  wire logic signed [DW-1:0]   i_dc,
    input  wire t_dp_cmd                i_cmd,
    output t_dp_stat                    o_stat,
    input  wire logic                   i_out_ready,
    output logic                        o_out_valid,
    output logic signed [DW-1:0]        o_membrane,
    output logic signed [DW-1:0]        o_recovery,
    output logic                        o_spike
);

    function automatic logic signed [ACC_W-1:0] ext_acc(input logic signed [DW-1:0] v);
        ext_acc = {{(ACC_W-DW){v[DW-1]}}, v};
    endfunction

    // configuration
    logic signed [DW-1:0]   r_alpha;
    logic [MU_W-1:0]        r_mu;
    logic signed [DW-1:0]   r_sigma_bias;
    logic signed [DW-1:0]   r_sig_syn;
    logic signed [DW-1:0]   r_beta_syn;
    logic signed [DW-1:0]   r_sig_dc;
    logic signed [DW-1:0]   r_beta_dc;

    // neuron state
    logic signed [DW-1:0]   r_xl;
    logic signed [DW-1:0]   r_xbl;
    logic signed [DW-1:0]   r_slow;

    // item operands and partial results
    logic signed [DW-1:0]   r_syn;
    logic signed [DW-1:0]   r_dc;
    logic signed [PROD_W-1:0] r_prod;
    t_mul_op                r_prod_op;
    logic                   r_prod_vld;
    logic signed [ACC_W-1:0] r_sacc;
    logic signed [ACC_W-1:0] r_bacc;
    logic signed [ACC_W-1:0] r_yacc;

    // output beat
    logic                   r_out_valid;
    logic signed [DW-1:0]   r_out_mem;
    logic signed [DW-1:0]   r_out_rec;
    logic                   r_out_spike;

    logic signed [MUL_W-1:0] mul_a;
    logic signed [MUL_W-1:0] mul_b;
    logic signed [MUL_W-1:0] mu_ext;
    logic signed [DW:0]      x_inc;
    logic signed [DW-1:0]    sigma_n;
    logic signed [ACC_W-1:0] term;
    logic signed [DW:0]      den_full;
    logic                    div_busy;
    logic signed [DW+1:0]    quot;
    logic signed [ACC_W-1:0] one_acc;
    logic signed [DW-1:0]    beta_n;
    logic signed [DW-1:0]    q_sat;
    logic signed [DW-1:0]    x_div;
    logic signed [DW-1:0]    thr;
    logic signed [DW-1:0]    x_new;
    logic signed [DW-1:0]    y_new;
    logic                    xl_pos;
    logic                    xbl_nonpos;
    logic                    spike;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha      <= RST_ALPHA;
            r_mu         <= RST_MU[MU_W-1:0];
            r_sigma_bias <= RST_SIGMA_BIAS;
            r_sig_syn    <= RST_SIG_GAIN;
            r_beta_syn   <= RST_BETA_GAIN;
            r_sig_dc     <= RST_SIG_GAIN;
            r_beta_dc    <= RST_BETA_GAIN;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_ALPHA:      r_alpha      <= i_cfg_data[DW-1:0];
                CFG_MU:         r_mu         <= i_cfg_data[MU_W-1:0];
                CFG_SIGMA_BIAS: r_sigma_bias <= i_cfg_data[DW-1:0];
                CFG_SIG_SYN:    r_sig_syn    <= i_cfg_data[DW-1:0];
                CFG_BETA_SYN:   r_beta_syn   <= i_cfg_data[DW-1:0];
                CFG_SIG_DC:     r_sig_dc     <= i_cfg_data[DW-1:0];
                CFG_BETA_DC:    r_beta_dc    <= i_cfg_data[DW-1:0];
                default: ;
            endcase
        end
    end

    // Divisor 1 - x_last; only meaningful when x_last <= 0.
    assign den_full = {1'b0, ONE} - {r_xl[DW-1], r_xl};

    rsn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.load),
        .i_alpha (r_alpha),
        .i_den   (den_full),
        .o_busy  (div_busy),
        .o_quot  (quot)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_syn <= i_syn;
            r_dc  <= i_dc;
        end
    end

    // Shared multiplier: operands selected per step, product registered.
    assign mu_ext  = {2'b00, r_mu};
    assign x_inc   = {r_xl[DW-1], r_xl} + {1'b0, ONE};
    assign sigma_n = sat_acc(r_sacc);

    always_comb begin
        unique case (i_cmd.mul_op)
            MUL_SIG_SYN: begin
                mul_a = {r_sig_syn[DW-1], r_sig_syn};
                mul_b = {r_syn[DW-1], r_syn};
            end
            MUL_SIG_DC: begin
                mul_a = {r_sig_dc[DW-1], r_sig_dc};
                mul_b = {r_dc[DW-1], r_dc};
            end
            MUL_BETA_SYN: begin
                mul_a = {r_beta_syn[DW-1], r_beta_syn};
                mul_b = {r_syn[DW-1], r_syn};
            end
            MUL_BETA_DC: begin
                mul_a = {r_beta_dc[DW-1], r_beta_dc};
                mul_b = {r_dc[DW-1], r_dc};
            end
            MUL_MU_X: begin
                mul_a = mu_ext;
                mul_b = x_inc;
            end
            MUL_MU_BIAS: begin
                mul_a = mu_ext;
                mul_b = {r_sigma_bias[DW-1], r_sigma_bias};
            end
            MUL_MU_SIG: begin
                mul_a = mu_ext;
                mul_b = {sigma_n[DW-1], sigma_n};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_cmd.mul_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod    <= mul_a * mul_b;
            r_prod_op <= i_cmd.mul_op;
        end
    end

    // Arithmetic shift of the signed product floors toward minus infinity.
    assign term = ACC_W'(r_prod >>> FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (r_prod_vld) begin
            unique case (r_prod_op)
                MUL_SIG_SYN:  r_sacc <= term;
                MUL_SIG_DC:   r_sacc <= r_sacc + term;
                MUL_BETA_SYN: r_bacc <= term;
                MUL_BETA_DC:  r_bacc <= r_bacc + term;
                MUL_MU_X:     r_yacc <= ext_acc(r_slow) - term;
                MUL_MU_BIAS:  r_yacc <= r_yacc + term;
                MUL_MU_SIG:   r_yacc <= r_yacc + term;
                default: ;
            endcase
        end
    end

    // Map update
    assign one_acc = ext_acc(ONE);

    always_comb begin
        if (r_bacc > one_acc) begin
            beta_n = ONE;
        end else if (r_bacc < -one_acc) begin
            beta_n = -ONE;
        end else begin
            beta_n = r_bacc[DW-1:0];
        end
    end

    assign q_sat      = sat_acc({{(ACC_W-DW-2){quot[DW+1]}}, quot});
    assign x_div      = sat_acc(ext_acc(q_sat) + ext_acc(r_slow) + ext_acc(beta_n));
    assign thr        = sat_acc(ext_acc(r_alpha) + ext_acc(r_slow) + ext_acc(beta_n));
    assign xl_pos     = ~r_xl[DW-1] && (r_xl != '0);
    assign xbl_nonpos = r_xbl[DW-1] || (r_xbl == '0);
    assign spike      = xl_pos && (r_xl <= thr) && xbl_nonpos;
    assign y_new      = sat_acc(r_yacc);

    always_comb begin
        if (!xl_pos) begin
            x_new = x_div;
        end else if (spike) begin
            x_new = thr;
        end else begin
            x_new = -ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xl   <= RST_X;
            r_xbl  <= RST_X;
            r_slow <= RST_Y;
        end else if (i_cmd.finish) begin
            r_xbl  <= r_xl;
            r_xl   <= x_new;
            r_slow <= y_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_mem   <= x_new;
            r_out_rec   <= y_new;
            r_out_spike <= spike;
        end
    end

    assign o_stat.div_busy = div_busy;
    assign o_stat.out_hold = r_out_valid && !i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_membrane      = r_out_mem;
    assign o_recovery      = r_out_rec;
    assign o_spike         = r_out_spike;

`ifndef ASSERT_OFF
    a_finish_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> !div_busy)
        else $error("state update while divider still running");

    a_load_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> !div_busy && !r_prod_vld)
        else $error("new item loaded while previous work in flight");

    a_finish_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> !(r_out_valid && !i_out_ready))
        else $error("output beat overwritten before it was taken");

    a_spike_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish && spike |-> !x_new[DW-1] && (x_new != '0))
        else $error("spike branch produced non-positive membrane");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/rsn_ctrl.sv =====
// Controller FSM: accepts an item, steps the shared multiplier through its seven
// products, waits for the divider, then commits the update. Depends on rsn_pkg.
`default_nettype none

module rsn_ctrl
    import rsn_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_dp_stat   i_stat,
    output t_dp_cmd         o_cmd
);

    t_state     r_state;
    t_state     n_state;
    t_mul_op    r_step;
    t_mul_op    n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= MUL_SIG_SYN;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        o_in_ready   = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.mul_en = 1'b0;
        o_cmd.mul_op = r_step;
        o_cmd.finish = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_step     = MUL_SIG_SYN;
                    n_state    = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul_en = 1'b1;
                if (r_step == MUL_LAST) begin
                    n_state = ST_WAIT;
                end else begin
                    n_step = t_mul_op'(r_step + 1'b1);
                end
            end
            ST_WAIT: begin
                // last product accumulates during the first cycle here
                if (!i_stat.div_busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!i_stat.out_hold) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rulkov_regular_spiking_neuron.sv =====
// Top level of the regular-spiking map neuron: controller plus datapath.
// Depends on rsn_pkg, rsn_in_if, rsn_out_if, rsn_ctrl and rsn_dp.
//
//   channel   dir  handshake      beat contents
//   i_in      in   valid/ready    syn_current, dc_current
//   o_out     out  valid/ready    membrane, recovery, spike
//   i_cfg_*   in   write enable   register index, write data
//
// The result is committed to the output register after the bit-serial divider, computing
// alpha / (1 - x) one bit a cycle, has finished; the next beat is taken only after that
// commit, back in idle, so the divider sets the rate of beats;
// the seven multiplies share one multiplier and overlap the divider.
// Reset is synchronous: it restores the register defaults and the resting state.
// i_in.ready is high only while idle; a held result stalls the commit until taken.
`default_nettype none

module rulkov_regular_spiking_neuron
    import rsn_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    rsn_in_if.sink                      i_in,
    rsn_out_if.source                   o_out
);

    t_dp_cmd    cmd;
    t_dp_stat   stat;
    logic       in_ready;
    logic       out_valid;
    logic signed [DW-1:0] membrane;
    logic signed [DW-1:0] recovery;
    logic       spike;

    rsn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    rsn_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_syn       (i_in.syn_current),
        .i_dc        (i_in.dc_current),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (o_out.ready),
        .o_out_valid (out_valid),
        .o_membrane  (membrane),
        .o_recovery  (recovery),
        .o_spike     (spike)
    );

    assign i_in.ready     = in_ready;
    assign o_out.valid    = out_valid;
    assign o_out.membrane = membrane;
    assign o_out.recovery = recovery;
    assign o_out.spike    = spike;

endmodule

`default_nettype wire
